// ===== design/jacobi_linear_solver_unit_assert.svh =====
// Assertion macros used by the solver unit
`ifndef JACOBI_LINEAR_SOLVER_UNIT_ASSERT_SVH
`define JACOBI_LINEAR_SOLVER_UNIT_ASSERT_SVH

// Implication checked every clock outside reset
`define JLS_ASSERT_IMPL(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset
`define JLS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

// ===== design/jls_pkg.sv =====
package jls_pkg;

    localparam int ORDER   = 32;
    localparam int VALUE_W = 32;
    localparam int SUM_W   = 48;
    localparam int ACC_W   = 64;

    typedef enum logic [1:0] {
        CMD_LOAD_A   = 2'd0,
        CMD_LOAD_B   = 2'd1,
        CMD_LOAD_X   = 2'd2,
        CMD_START    = 2'd3
    } t_cmd;

    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_LIMIT     = 1'b1;

    typedef struct packed {
        logic [1:0]         command;
        logic [4:0]         row;
        logic [4:0]         column;
        logic signed [31:0] value_in;
    } t_in_item;

    typedef struct packed {
        logic [4:0]         index;
        logic signed [31:0] solution;
        logic               last;
        logic               converged;
        logic [15:0]        sweeps;
        logic [47:0]        error_sum;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAC,
        ST_MAC_WAIT,
        ST_ROW,
        ST_DIV,
        ST_UPDATE,
        ST_CHECK,
        ST_ERR,
        ST_ERR_WAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic zero_div;
        logic neg;
    } t_div_ctl;

    function automatic logic [SUM_W-1:0] sat_add48(input logic [SUM_W-1:0] s,
                                                   input logic [ACC_W-1:0] m);
        logic [ACC_W:0] t;
        begin
            t = {1'b0, m} + {{(ACC_W-SUM_W+1){1'b0}}, s};
            if (t[ACC_W:SUM_W] != '0) begin
                sat_add48 = '1;
            end else begin
                sat_add48 = t[SUM_W-1:0];
            end
        end
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_add64(input logic signed [ACC_W-1:0] a,
                                                          input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W-1:0] t;
        begin
            t = a + b;
            if (a[ACC_W-1] == b[ACC_W-1] && t[ACC_W-1] != a[ACC_W-1]) begin
                sat_add64 = a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
            end else begin
                sat_add64 = t;
            end
        end
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [ACC_W:0] v);
        begin
            if (v > $signed(65'sh7FFFFFFF)) begin
                clamp32 = 32'sh7FFFFFFF;
            end else if (v < -$signed(65'sh80000000)) begin
                clamp32 = 32'sh80000000;
            end else begin
                clamp32 = v[31:0];
            end
        end
    endfunction

endpackage

// ===== design/jls_ram.sv =====
module jls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== design/jls_divider.sv =====
// Restoring divider, one quotient bit per cycle; quotient saturates to 32 bits
module jls_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  jls_pkg::t_div_ctl         i_ctl,
    input  logic signed [63:0]        i_num,
    input  logic signed [31:0]        i_den,
    output logic                      o_done,
    output logic signed [31:0]        o_quot
);
    logic [63:0] r_rem, n_rem;
    logic [63:0] r_q, n_q;
    logic [63:0] r_den;
    logic        r_neg;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [64:0] shifted;
    logic [64:0] trial;
    logic signed [64:0] signed_q;

    always_comb begin
        shifted = {r_rem, r_q[63]};
        trial   = shifted - {1'b0, r_den};
        if (!trial[64]) begin
            n_rem = trial[63:0];
            n_q   = {r_q[62:0], 1'b1};
        end else begin
            n_rem = shifted[63:0];
            n_q   = {r_q[62:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= '0;
            r_q   <= i_num[63] ? 64'(-i_num) : i_num;
            r_den <= i_den[31] ? 64'(-{{32{i_den[31]}}, i_den}) : {32'd0, i_den};
            r_neg <= i_num[63] ^ i_den[31];
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    // magnitude quotient is unsigned 64 bits; apply sign then clamp
    assign signed_q = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
    assign o_done   = r_done;
    assign o_quot   = jls_pkg::clamp32(signed_q);
endmodule

// ===== design/jacobi_linear_solver_unit.sv =====
// Each load is written when it is accepted. A start runs sweeps of ORDER rows;
// each row is a multiply-accumulate over the matrix memory, a pipeline drain,
// a residual step, a divide and an update, and each sweep ends with the check.
// After a converged run an error pass follows; after it, or once the sweep limit
// is reached, ORDER results come out, one per cycle, with no stall. Start is
// refused (busy high) until the last result. Sync reset to defaults.
module jacobi_linear_solver_unit #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  jls_pkg::t_in_item    i_item,
    output logic                 o_valid,
    output jls_pkg::t_out_item   o_item,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [31:0]          i_cfg_data
);
    localparam int ORDER = jls_pkg::ORDER;
    localparam int IW = $clog2(ORDER);
    localparam int AW = 2 * IW;

    jls_pkg::t_state r_state, n_state;

    logic [31:0] r_thresh;
    logic [15:0] r_limit;
    logic        r_bank;
    logic [15:0] r_sweeps;
    logic [47:0] r_change;
    logic [47:0] r_err;
    logic        r_conv;
    logic [IW:0] r_i;
    logic [IW:0] r_j;
    logic [IW:0] r_pipe_j;
    logic        r_pipe_v;
    logic signed [63:0] r_prod;
    logic        r_prod_v;
    logic signed [63:0] r_acc;
    logic signed [31:0] r_diag;
    logic signed [31:0] r_xi;
    logic signed [63:0] r_res;
    logic        r_last_pending;
    logic        r_div_go;

    logic        accept;
    logic [1:0]  cmd;
    logic        row_ok, col_ok;

    logic          a_we;
    logic [AW-1:0] a_waddr, a_raddr;
    logic [31:0]   a_rdata;
    logic          b_we;
    logic [IW-1:0] b_waddr, b_raddr;
    logic [31:0]   b_rdata;
    logic          x_we;
    logic [IW:0]   x_waddr, x_raddr;
    logic [31:0]   x_wdata, x_rdata;

    jls_pkg::t_div_ctl div_ctl;
    logic          div_done;
    logic signed [31:0] div_q;
    logic signed [31:0] dx;
    logic signed [63:0] b_scaled;
    logic signed [63:0] neg_acc;

    assign accept = start && !busy;
    assign cmd    = i_item.command;
    assign row_ok = 32'(i_item.row) < ORDER;
    assign col_ok = 32'(i_item.column) < ORDER;
    assign busy   = (r_state != jls_pkg::ST_IDLE);

    jls_ram #(.WIDTH(32), .DEPTH(ORDER * ORDER)) u_a (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_waddr), .i_wdata(i_item.value_in),
        .i_raddr(a_raddr), .o_rdata(a_rdata));
    jls_ram #(.WIDTH(32), .DEPTH(ORDER)) u_b (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(b_waddr), .i_wdata(i_item.value_in),
        .i_raddr(b_raddr), .o_rdata(b_rdata));
    jls_ram #(.WIDTH(32), .DEPTH(2 * ORDER)) u_x (
        .i_clk(i_clk), .i_we(x_we), .i_waddr(x_waddr), .i_wdata(x_wdata),
        .i_raddr(x_raddr), .o_rdata(x_rdata));

    jls_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(div_ctl),
        .i_num(r_res), .i_den(r_diag), .o_done(div_done), .o_quot(div_q));

    assign a_we    = accept && cmd == jls_pkg::CMD_LOAD_A && row_ok && col_ok;
    assign a_waddr = {i_item.row[IW-1:0], i_item.column[IW-1:0]};
    assign b_we    = accept && cmd == jls_pkg::CMD_LOAD_B && row_ok;
    assign b_waddr = i_item.row[IW-1:0];
    assign a_raddr = {r_i[IW-1:0], r_j[IW-1:0]};
    assign b_raddr = r_i[IW-1:0];

    // zero diagonal and the -1 overflow case both saturate by sign
    always_comb begin
        if (r_diag == 0) begin
            dx = r_res[63] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end else if (r_diag == -32'sd1 && r_res == {1'b1, 63'd0}) begin
            dx = 32'sh7FFFFFFF;
        end else begin
            dx = div_q;
        end
    end

    always_comb begin
        x_we    = 1'b0;
        x_waddr = {r_bank, i_item.row[IW-1:0]};
        x_wdata = i_item.value_in;
        if (accept && cmd == jls_pkg::CMD_LOAD_X && row_ok) begin
            x_we = 1'b1;
        end else if (r_state == jls_pkg::ST_UPDATE) begin
            x_we    = 1'b1;
            x_waddr = {~r_bank, r_i[IW-1:0]};
            x_wdata = jls_pkg::clamp32(65'(r_xi) + 65'(dx));
        end
    end

    // fetch x_i while the pipeline drains so it is ready in the residual cycle
    always_comb begin
        x_raddr = {r_bank, r_j[IW-1:0]};
        if (r_state == jls_pkg::ST_MAC_WAIT || r_state == jls_pkg::ST_ROW) begin
            x_raddr = {r_bank, r_i[IW-1:0]};
        end
    end

    assign b_scaled = 64'($signed(b_rdata)) <<< FRACTION_BITS;
    assign neg_acc  = (r_acc == {1'b1, 63'd0}) ? {1'b0, {63{1'b1}}} : -r_acc;

    always_comb begin
        div_ctl          = '0;
        div_ctl.start    = (r_state == jls_pkg::ST_DIV) && r_div_go;
        div_ctl.zero_div = (r_diag == 0);
        div_ctl.neg      = r_res[63];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            jls_pkg::ST_IDLE: begin
                if (accept && cmd == jls_pkg::CMD_START) begin
                    n_state = (r_limit == 16'd0) ? jls_pkg::ST_OUT : jls_pkg::ST_MAC;
                end
            end
            jls_pkg::ST_MAC:      if (32'(r_j) == ORDER - 1) n_state = jls_pkg::ST_MAC_WAIT;
            jls_pkg::ST_MAC_WAIT: if (!r_prod_v && !r_pipe_v) n_state = jls_pkg::ST_ROW;
            jls_pkg::ST_ROW:      n_state = jls_pkg::ST_DIV;
            jls_pkg::ST_DIV:      if (div_done) n_state = jls_pkg::ST_UPDATE;
            jls_pkg::ST_UPDATE: begin
                n_state = (32'(r_i) == ORDER - 1) ? jls_pkg::ST_CHECK : jls_pkg::ST_MAC;
            end
            jls_pkg::ST_CHECK: begin
                if (r_change <= 48'(r_thresh)) n_state = jls_pkg::ST_ERR;
                else if (r_sweeps == r_limit) n_state = jls_pkg::ST_OUT;
                else n_state = jls_pkg::ST_MAC;
            end
            jls_pkg::ST_ERR:      if (32'(r_j) == ORDER - 1) n_state = jls_pkg::ST_ERR_WAIT;
            jls_pkg::ST_ERR_WAIT: if (!r_pipe_v) n_state = jls_pkg::ST_OUT;
            jls_pkg::ST_OUT:      if (32'(r_j) == ORDER - 1) n_state = jls_pkg::ST_IDLE;
            default:              n_state = jls_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= jls_pkg::ST_IDLE;
            r_thresh <= 32'd66;
            r_limit  <= 16'd1000;
            r_bank   <= 1'b0;
            r_sweeps <= '0;
            r_change <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_pipe_v <= 1'b0;
            r_prod_v <= 1'b0;
            r_conv   <= 1'b0;
            r_last_pending <= 1'b0;
            r_div_go <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we && i_cfg_index == jls_pkg::CFG_THRESHOLD) r_thresh <= i_cfg_data;
            if (i_cfg_we && i_cfg_index == jls_pkg::CFG_LIMIT) r_limit <= i_cfg_data[15:0];
            r_pipe_v <= (r_state == jls_pkg::ST_MAC) || (r_state == jls_pkg::ST_ERR);
            r_prod_v <= r_pipe_v && (r_state == jls_pkg::ST_MAC || r_state == jls_pkg::ST_MAC_WAIT);
            r_pipe_j <= r_j;
            r_last_pending <= (r_state == jls_pkg::ST_OUT) && (32'(r_j) == ORDER - 1);
            // launch the divider once, on the first divide cycle
            r_div_go <= (r_state == jls_pkg::ST_ROW);
            case (r_state)
                jls_pkg::ST_IDLE: begin
                    r_i <= '0;
                    r_j <= '0;
                    if (accept && cmd == jls_pkg::CMD_START) begin
                        r_sweeps <= '0;
                        r_change <= '0;
                        r_conv   <= 1'b0;
                        r_err    <= '0;
                    end
                end
                jls_pkg::ST_MAC: begin
                    r_j <= r_j + 1'b1;
                end
                jls_pkg::ST_ROW: begin
                    r_res <= (r_acc == {1'b1, 63'd0}) ?
                             jls_pkg::sat_add64(jls_pkg::sat_add64(b_scaled, neg_acc), 64'sd1) :
                             jls_pkg::sat_add64(b_scaled, neg_acc);
                end
                jls_pkg::ST_UPDATE: begin
                    r_j <= '0;
                    r_i <= r_i + 1'b1;
                    r_change <= jls_pkg::sat_add48(r_change,
                        dx[31] ? 64'(-65'(dx)) : 64'(dx));
                    if (32'(r_i) == ORDER - 1) begin
                        r_bank   <= ~r_bank;
                        r_sweeps <= r_sweeps + 16'd1;
                    end
                end
                jls_pkg::ST_CHECK: begin
                    r_i <= '0;
                    r_j <= '0;
                    if (r_change <= 48'(r_thresh)) begin
                        r_conv <= 1'b1;
                        r_err  <= '0;
                    end else begin
                        r_err <= r_change;
                        if (r_sweeps != r_limit) r_change <= '0;
                    end
                end
                jls_pkg::ST_ERR: r_j <= r_j + 1'b1;
                jls_pkg::ST_ERR_WAIT: r_j <= '0;
                jls_pkg::ST_OUT: r_j <= r_j + 1'b1;
                default: ;
            endcase
            if (r_pipe_v && (r_state == jls_pkg::ST_ERR || r_state == jls_pkg::ST_ERR_WAIT)) begin
                r_err <= jls_pkg::sat_add48(r_err,
                    64'(($signed(x_rdata) < (32'sd1 <<< FRACTION_BITS)) ?
                        (65'sd1 <<< FRACTION_BITS) - 65'($signed(x_rdata)) :
                        65'($signed(x_rdata)) - (65'sd1 <<< FRACTION_BITS)));
            end
        end
    end

    // MAC pipeline: read, multiply, accumulate
    always_ff @(posedge i_clk) begin
        if (r_state == jls_pkg::ST_MAC && r_j == '0) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= jls_pkg::sat_add64(r_acc, r_prod);
        end
        r_prod <= 64'($signed(a_rdata)) * 64'($signed(x_rdata));
        if (r_pipe_v && r_state != jls_pkg::ST_ERR && r_state != jls_pkg::ST_ERR_WAIT
            && r_pipe_j == r_i) begin
            r_diag <= a_rdata;
        end
        if (r_state == jls_pkg::ST_ROW) begin
            r_xi <= x_rdata;
        end
    end

    // output stage: one result per cycle from the current bank
    logic [IW-1:0] r_oidx;
    logic          r_ov;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= (r_state == jls_pkg::ST_OUT);
        end
        r_oidx <= r_j[IW-1:0];
    end

    assign o_valid            = r_ov;
    assign o_item.index       = 5'(r_oidx);
    assign o_item.solution    = x_rdata;
    assign o_item.last        = r_last_pending;
    assign o_item.converged   = r_conv;
    assign o_item.sweeps      = r_sweeps;
    assign o_item.error_sum   = r_err;

    `include "jacobi_linear_solver_unit_assert.svh"
    `JLS_ASSERT_IMPL(a_last_valid, i_clk, i_rst_n, o_item.last, o_valid)
    `JLS_ASSERT_IMPL(a_busy_out, i_clk, i_rst_n, o_valid && !o_item.last, busy)
    `JLS_ASSERT_NEXT(a_div_busy, i_clk, i_rst_n, div_ctl.start, r_state == jls_pkg::ST_DIV)
endmodule
